@@ hw/rtl/mfr_pkg.sv @@
// Package for the MBAP frame receiver: phase, status and operation codes,
// channel item types and frame size constants. No dependencies.
`default_nettype none

package mfr_pkg;

  // Frame geometry
  localparam int unsigned HEADER_BYTES    = 7;
  localparam int unsigned MAX_FRAME_BYTES = 260;
  localparam int unsigned LEN_MIN         = 2;
  localparam int unsigned LEN_MAX         = 254;
  localparam int unsigned TIMEOUT_RESET   = 1000;

  // Request operation codes
  typedef enum logic [1:0] {
    OP_DATA    = 2'd0,
    OP_TIME    = 2'd1,
    OP_RESTART = 2'd2,
    OP_SPARE   = 2'd3
  } op_t;

  // Receiver phase
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PDU    = 2'd1,
    PH_DONE   = 2'd2,
    PH_ERROR  = 2'd3
  } phase_t;

  // Result status
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DONE    = 2'd1,
    ST_HDR_ERR = 2'd2,
    ST_REJECT  = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  byte_in;
    logic [31:0] time_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  phase;
    logic [7:0]  byte_out;
    logic [8:0]  byte_index;
    logic        byte_valid;
    logic        timed_out;
    logic [15:0] txn_id;
    logic [7:0]  unit_id;
    logic [8:0]  frame_bytes;
  } out_item_t;

  typedef logic [31:0] cfg_word_t;

endpackage

`default_nettype wire

@@ hw/rtl/mfr_stream_if.sv @@
// Valid/ready channel interface carrying one payload of a given type.
// Used for the request, result and configuration channels; no dependencies.
`default_nettype none

interface mfr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mbap_frame_receiver_top.sv @@
// MBAP (Modbus TCP) frame receiver, one byte per request.
// Depends on mfr_pkg and mfr_stream_if.
`default_nettype none

// Usage:
//   in_ch  : requests {operation, byte_in, time_ms}; operation selects data
//            byte, time check only, or restart (code 3 acts as time check).
//   out_ch : one result per request: status, phase, echoed byte with its
//            frame index, timeout flag, transaction id, unit id, byte count.
//   cfg_ch : writes the 32-bit timeout in ms; always ready. Write it only
//            while no request is in flight.
// Path: an accepted request sits in the input register, is processed
//   from there and its result goes into the output register.
// Throughput: one request per cycle unless out_ch stalls; receiver state
//   (phase, byte count, header words, start stamp) is updated with the result.
// Stall: when out_ch.ready is low and a result is held, the input register
//   holds too and in_ch.ready drops once it is occupied.
// Reset (rst_n low, synchronous): both stages empty, header phase, count 0,
//   header words and start stamp 0, timeout 1000 ms.
module mbap_frame_receiver_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  mfr_stream_if.sink   in_ch,
  mfr_stream_if.source out_ch,
  mfr_stream_if.sink   cfg_ch
);
  import mfr_pkg::*;

  // Header byte positions
  localparam logic [2:0] POS_TXN_HI   = 3'd0;
  localparam logic [2:0] POS_TXN_LO   = 3'd1;
  localparam logic [2:0] POS_PROTO_HI = 3'd2;
  localparam logic [2:0] POS_PROTO_LO = 3'd3;
  localparam logic [2:0] POS_LEN_HI   = 3'd4;
  localparam logic [2:0] POS_LEN_LO   = 3'd5;
  localparam logic [2:0] POS_UNIT     = 3'd6;

  // Pipeline control
  logic      s1_valid_r;
  in_item_t  s1_r;
  logic      out_valid_r;
  out_item_t out_r;
  logic      advance;
  logic      s1_fire;

  // Receiver state
  phase_t      phase_r, phase_nxt;
  logic [8:0]  byte_count_r, byte_count_nxt;
  logic [8:0]  frame_end_r, frame_end_nxt;
  logic [31:0] start_stamp_r, start_stamp_nxt;
  logic [15:0] txn_r, txn_nxt;
  logic [15:0] proto_r, proto_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  unit_r, unit_nxt;
  logic [31:0] timeout_r;

  // Per-request work signals
  out_item_t   res_nxt;
  status_t     status_nxt;
  logic [8:0]  cnt_inc;
  logic [16:0] total;
  logic [31:0] elapsed;
  logic        hdr_bad;

  assign advance     = !out_valid_r || out_ch.ready;
  assign s1_fire     = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

  // Request processing: phase tracking, header capture, timeout check
  always_comb begin
    phase_nxt       = phase_r;
    byte_count_nxt  = byte_count_r;
    frame_end_nxt   = frame_end_r;
    start_stamp_nxt = start_stamp_r;
    txn_nxt         = txn_r;
    proto_nxt       = proto_r;
    len_nxt         = len_r;
    unit_nxt        = unit_r;
    status_nxt      = ST_OK;
    cnt_inc         = byte_count_r + 9'd1;
    total           = 17'(HEADER_BYTES - 1) + 17'(len_r);
    hdr_bad         = 1'b0;
    res_nxt         = '0;

    unique case (op_t'(s1_r.operation))
      OP_RESTART: begin
        phase_nxt      = PH_HEADER;
        byte_count_nxt = '0;
        frame_end_nxt  = 9'(HEADER_BYTES);
      end
      OP_DATA: begin
        if (phase_r == PH_DONE || phase_r == PH_ERROR) begin
          status_nxt = ST_REJECT;
        end else begin
          if (byte_count_r == '0) begin
            start_stamp_nxt = s1_r.time_ms;
          end
          res_nxt.byte_out   = s1_r.byte_in;
          res_nxt.byte_index = byte_count_r;
          res_nxt.byte_valid = 1'b1;
          // Header capture: each byte fills its own half word or the unit id
          if (phase_r == PH_HEADER) begin
            unique case (byte_count_r[2:0])
              POS_TXN_HI:   txn_nxt[15:8]   = s1_r.byte_in;
              POS_TXN_LO:   txn_nxt[7:0]    = s1_r.byte_in;
              POS_PROTO_HI: proto_nxt[15:8] = s1_r.byte_in;
              POS_PROTO_LO: proto_nxt[7:0]  = s1_r.byte_in;
              POS_LEN_HI:   len_nxt[15:8]   = s1_r.byte_in;
              POS_LEN_LO:   len_nxt[7:0]    = s1_r.byte_in;
              POS_UNIT:     unit_nxt        = s1_r.byte_in;
              default: ;
            endcase
          end
          byte_count_nxt = cnt_inc;
          // End of header or end of frame
          if (cnt_inc >= frame_end_r) begin
            if (phase_r == PH_HEADER) begin
              // unit id is the last header byte, so all words are final here
              total   = 17'(HEADER_BYTES - 1) + 17'(len_nxt);
              hdr_bad = (proto_nxt != '0) || (len_nxt < 16'(LEN_MIN)) ||
                        (len_nxt > 16'(LEN_MAX)) ||
                        (total > 17'(MAX_FRAME_BYTES));
              if (hdr_bad) begin
                phase_nxt  = PH_ERROR;
                status_nxt = ST_HDR_ERR;
              end else begin
                frame_end_nxt = 9'(total);
                phase_nxt     = PH_PDU;
              end
            end else begin
              phase_nxt  = PH_DONE;
              status_nxt = ST_DONE;
            end
          end
        end
      end
      default: ;
    endcase

    // Timeout on a partly received frame, wrapping subtraction
    elapsed = s1_r.time_ms - start_stamp_nxt;
    res_nxt.timed_out = (phase_nxt == PH_HEADER || phase_nxt == PH_PDU) &&
                        (byte_count_nxt != '0) && (elapsed >= timeout_r);

    res_nxt.status      = status_nxt;
    res_nxt.phase       = phase_nxt;
    res_nxt.txn_id      = txn_nxt;
    res_nxt.unit_id     = unit_nxt;
    res_nxt.frame_bytes = byte_count_nxt;
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      phase_r       <= PH_HEADER;
      byte_count_r  <= '0;
      frame_end_r   <= 9'(HEADER_BYTES);
      start_stamp_r <= '0;
      txn_r         <= '0;
      proto_r       <= '0;
      len_r         <= '0;
      unit_r        <= '0;
      timeout_r     <= 32'(TIMEOUT_RESET);
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        phase_r       <= phase_nxt;
        byte_count_r  <= byte_count_nxt;
        frame_end_r   <= frame_end_nxt;
        start_stamp_r <= start_stamp_nxt;
        txn_r         <= txn_nxt;
        proto_r       <= proto_nxt;
        len_r         <= len_nxt;
        unit_r        <= unit_nxt;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        timeout_r <= cfg_ch.payload;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_r <= in_ch.payload;
    end
    if (s1_fire) begin
      out_r <= res_nxt;
    end
  end

`ifndef SYNTH
  // An echoed byte never comes with a reject
  a_valid_not_rejected: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.byte_valid) |-> (out_r.status != ST_REJECT))
    else $error("accepted byte reported as rejected");

  // Frame completion leaves the receiver in the complete phase
  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_DONE) |-> (out_r.phase == PH_DONE))
    else $error("frame completed without complete phase");

  // Timeout only for a partly received frame
  a_timeout_partial: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.timed_out) |->
      ((out_r.phase == PH_HEADER || out_r.phase == PH_PDU) &&
       out_r.frame_bytes != '0))
    else $error("timeout flagged outside a partial frame");

  // Byte count never runs past the frame limit
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_count_r <= 9'(MAX_FRAME_BYTES))
    else $error("byte count beyond frame limit");
`endif

endmodule

`default_nettype wire

@@ sim/tb_mbap_frame_receiver_top.sv @@
// Testbench for mbap_frame_receiver_top: directed and random byte streams with
// a built-in predictor of the MBAP deframer, checked result by result.
// Depends on mfr_pkg, mfr_stream_if and the receiver RTL.

module tb_mbap_frame_receiver_top;
  import mfr_pkg::*;

  logic clk;
  logic rst_n;

  mfr_stream_if #(.payload_t(in_item_t))  in_if ();
  mfr_stream_if #(.payload_t(out_item_t)) out_if ();
  mfr_stream_if #(.payload_t(cfg_word_t)) cfg_if ();

  mbap_frame_receiver_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // Requests waiting for the driver, results waiting for the monitor
  in_item_t  request_queue[$];
  out_item_t due_results[$];

  // Deframer state as the predictor sees it
  phase_t      rx_ph       = PH_HEADER;
  logic [8:0]  rx_count    = '0;
  logic [8:0]  rx_end      = 9'(HEADER_BYTES);
  logic [31:0] first_stamp = '0;
  logic [15:0] txn_hold    = '0;
  logic [15:0] proto_hold  = '0;
  logic [15:0] len_hold    = '0;
  logic [7:0]  unit_hold   = '0;
  logic [31:0] timeout_reg = TIMEOUT_RESET;

  // Stimulus bookkeeping
  logic [31:0] stamp_ms = 32'hFFFF_FE00;
  int queued_cnt       = 0;
  int accepted_cnt     = 0;
  int result_cnt       = 0;
  int errors           = 0;
  int long_frames_left = 2;
  int cfg_writes       = 0;
  int frames_done      = 0;
  int hdr_errors       = 0;
  int rejects          = 0;
  int timeouts_seen    = 0;
  logic hold_off;

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // One step of the deframer: updates predictor state, returns the result
  function automatic out_item_t deframe_step(input in_item_t it);
    out_item_t   r;
    int unsigned total_len;
    r = '0;
    case (op_t'(it.operation))
      OP_RESTART: begin
        rx_ph    = PH_HEADER;
        rx_count = '0;
        rx_end   = 9'(HEADER_BYTES);
      end
      OP_DATA: begin
        if (rx_ph == PH_DONE || rx_ph == PH_ERROR) begin
          r.status = ST_REJECT;
        end else begin
          if (rx_count == 0) first_stamp = it.time_ms;
          r.byte_out   = it.byte_in;
          r.byte_index = rx_count;
          r.byte_valid = 1'b1;
          // header bytes land in their own half of each word or in the unit id
          if (rx_ph == PH_HEADER) begin
            case (rx_count)
              9'd0: txn_hold[15:8]   = it.byte_in;
              9'd1: txn_hold[7:0]    = it.byte_in;
              9'd2: proto_hold[15:8] = it.byte_in;
              9'd3: proto_hold[7:0]  = it.byte_in;
              9'd4: len_hold[15:8]   = it.byte_in;
              9'd5: len_hold[7:0]    = it.byte_in;
              9'd6: unit_hold        = it.byte_in;
              default: ;
            endcase
          end
          rx_count = rx_count + 9'd1;
          if (rx_count >= rx_end) begin
            if (rx_ph == PH_HEADER) begin
              total_len = HEADER_BYTES - 1 + len_hold;
              if (proto_hold != 0 || len_hold < LEN_MIN || len_hold > LEN_MAX ||
                  total_len > MAX_FRAME_BYTES) begin
                rx_ph    = PH_ERROR;
                r.status = ST_HDR_ERR;
              end else begin
                rx_end = 9'(total_len);
                rx_ph  = PH_PDU;
              end
            end else begin
              rx_ph    = PH_DONE;
              r.status = ST_DONE;
            end
          end
        end
      end
      default: ;
    endcase
    // timeout only for a partly received frame, wrapping elapsed time
    if ((rx_ph == PH_HEADER || rx_ph == PH_PDU) && rx_count != 0)
      r.timed_out = ((it.time_ms - first_stamp) >= timeout_reg);
    r.phase       = rx_ph;
    r.txn_id      = txn_hold;
    r.unit_id     = unit_hold;
    r.frame_bytes = rx_count;
    return r;
  endfunction

  // Driver: presents queued requests, predicts each accepted one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        due_results.push_back(deframe_step(in_if.payload));
        accepted_cnt++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (request_queue.size() != 0 &&
            ((accepted_cnt >= 560 && accepted_cnt < 720) ||
             $urandom_range(0, 99) >= 19)) begin
          in_if.valid   <= 1'b1;
          in_if.payload <= request_queue.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  // Monitor: compares each result with the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.payload;
        result_cnt++;
        if (due_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: expected none, got %h", $time, got);
        end else begin
          want = due_results.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("phase", 32'(want.phase), 32'(got.phase));
          check_field("byte_out", 32'(want.byte_out), 32'(got.byte_out));
          check_field("byte_index", 32'(want.byte_index), 32'(got.byte_index));
          check_field("byte_valid", 32'(want.byte_valid), 32'(got.byte_valid));
          check_field("timed_out", 32'(want.timed_out), 32'(got.timed_out));
          check_field("txn_id", 32'(want.txn_id), 32'(got.txn_id));
          check_field("unit_id", 32'(want.unit_id), 32'(got.unit_id));
          check_field("frame_bytes", 32'(want.frame_bytes), 32'(got.frame_bytes));
          if (want.status == ST_DONE) frames_done++;
          if (want.status == ST_HDR_ERR) hdr_errors++;
          if (want.status == ST_REJECT) rejects++;
          if (want.timed_out) timeouts_seen++;
        end
      end
      out_if.ready <= !hold_off &&
                      ((result_cnt >= 560 && result_cnt < 720) ||
                       $urandom_range(0, 99) >= 19);
    end
  end

  // Long receiver stall while requests are still queued, to fill the pipe
  initial begin
    hold_off = 1'b0;
    do @(negedge clk); while (!(accepted_cnt >= 350 && request_queue.size() > 20));
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (150) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Time stamps mostly creep, sometimes jump far enough to time out or wrap
  function automatic logic [31:0] advance_stamp();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) stamp_ms += $urandom_range(0, 16);
    else if (r < 93) stamp_ms += $urandom_range(0, 1500);
    else stamp_ms += $urandom();
    return stamp_ms;
  endfunction

  task automatic push_item(input op_t op, input logic [7:0] b);
    in_item_t it;
    it.operation = op;
    it.byte_in   = b;
    it.time_ms   = advance_stamp();
    request_queue.push_back(it);
    queued_cnt++;
  endtask

  // Header plus PDU bytes; cut > 0 stops early. Always ends with a restart.
  task automatic queue_frame(input logic [15:0] txn, input logic [15:0] proto,
                             input logic [15:0] len, input logic [7:0] unit,
                             input int cut);
    logic [55:0] hdr;
    int          total;
    int          n;
    hdr   = {txn, proto, len, unit};
    total = HEADER_BYTES;
    if (proto == 0 && len >= LEN_MIN && len <= LEN_MAX) total = HEADER_BYTES - 1 + len;
    n = (cut > 0 && cut < total) ? cut : total;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 4) push_item(OP_TIME, 8'($urandom));
      if (i < HEADER_BYTES) push_item(OP_DATA, hdr[55 - 8*i -: 8]);
      else push_item(OP_DATA, 8'($urandom));
    end
    // stray byte after complete or error gets rejected
    if (n == total && $urandom_range(0, 3) == 0) push_item(OP_DATA, 8'($urandom));
    push_item(OP_RESTART, 8'($urandom));
  endtask

  task automatic queue_random_traffic(input int budget);
    int unsigned r;
    int          stop;
    logic [15:0] len;
    stop = queued_cnt + budget;
    while (queued_cnt < stop) begin
      r   = $urandom_range(0, 99);
      len = 16'($urandom_range(LEN_MIN, 24));
      if (r < 62) begin
        queue_frame(16'($urandom), 16'h0, len, 8'($urandom), 0);
      end else if (r < 64) begin
        if (long_frames_left > 0) begin
          long_frames_left--;
          queue_frame(16'($urandom), 16'h0, 16'(LEN_MAX), 8'($urandom), 0);
        end
      end else if (r < 72) begin
        queue_frame(16'($urandom), 16'($urandom_range(1, 65535)), len, 8'($urandom), 0);
      end else if (r < 80) begin
        case ($urandom_range(0, 3))
          0:       len = 16'd0;
          1:       len = 16'(LEN_MIN - 1);
          2:       len = 16'(LEN_MAX + 1);
          default: len = 16'($urandom);
        endcase
        queue_frame(16'($urandom), 16'h0, len, 8'($urandom), 0);
      end else if (r < 90) begin
        queue_frame(16'($urandom), 16'h0, len, 8'($urandom),
                    $urandom_range(1, HEADER_BYTES - 2 + len));
      end else begin
        // noise: any operation, any byte
        repeat ($urandom_range(1, 6)) push_item(op_t'($urandom_range(0, 3)), 8'($urandom));
        push_item(OP_RESTART, 8'($urandom));
      end
    end
  endtask

  task automatic write_timeout(input cfg_word_t value);
    @(posedge clk);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    timeout_reg = value;
    cfg_writes++;
  endtask

  // Wait until every request is accepted and answered, then let the pipe settle
  task automatic wait_drained;
    do @(negedge clk);
    while (request_queue.size() != 0 || in_if.valid || due_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    cfg_word_t settings[5];
    int        drain;
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    out_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme header, wrapping time, exact timeout boundary,
    // spare opcode, rejects after complete and after a bad protocol id
    stamp_ms = 32'hFFFF_FE00;
    request_queue.push_back('{OP_TIME, 8'h5A, stamp_ms});
    request_queue.push_back('{OP_DATA, 8'hFF, stamp_ms});
    request_queue.push_back('{OP_DATA, 8'hFF, stamp_ms + 1});
    request_queue.push_back('{OP_DATA, 8'h00, stamp_ms + 2});
    request_queue.push_back('{OP_DATA, 8'h00, stamp_ms + 3});
    request_queue.push_back('{OP_DATA, 8'h00, stamp_ms + 4});
    request_queue.push_back('{OP_DATA, 8'h02, stamp_ms + 5});
    request_queue.push_back('{OP_DATA, 8'hFF, stamp_ms + 6});
    request_queue.push_back('{OP_SPARE, 8'hC3, stamp_ms + 32'h300});
    request_queue.push_back('{OP_TIME, 8'h00, stamp_ms + TIMEOUT_RESET});
    request_queue.push_back('{OP_DATA, 8'h00, stamp_ms + TIMEOUT_RESET + 1});
    request_queue.push_back('{OP_DATA, 8'hA5, stamp_ms + TIMEOUT_RESET + 2});
    request_queue.push_back('{OP_RESTART, 8'h00, stamp_ms + TIMEOUT_RESET + 3});
    request_queue.push_back('{OP_DATA, 8'h00, 32'h0000_0000});
    request_queue.push_back('{OP_DATA, 8'h00, 32'h0000_0001});
    request_queue.push_back('{OP_DATA, 8'h80, 32'h0000_0002});
    request_queue.push_back('{OP_DATA, 8'h01, 32'h0000_0003});
    request_queue.push_back('{OP_DATA, 8'h00, 32'h0000_0004});
    request_queue.push_back('{OP_DATA, 8'h04, 32'h0000_0005});
    request_queue.push_back('{OP_DATA, 8'h00, 32'h0000_0006});
    request_queue.push_back('{OP_DATA, 8'h3C, 32'hFFFF_FFFF});
    request_queue.push_back('{OP_RESTART, 8'hFF, 32'hFFFF_FFFF});
    queued_cnt += 22;
    wait_drained();

    // Random traffic under several timeout settings, extremes included
    settings[0] = 32'd0;
    settings[1] = 32'hFFFF_FFFF;
    settings[2] = 32'($urandom_range(1, 3000));
    settings[3] = 32'($urandom);
    settings[4] = TIMEOUT_RESET;
    foreach (settings[k]) begin
      write_timeout(settings[k]);
      queue_random_traffic(180);
      wait_drained();
    end

    // Final drain with a bound
    do @(negedge clk); while (request_queue.size() != 0 || in_if.valid);
    drain = 0;
    while (due_results.size() != 0 && drain < 5000) begin
      @(negedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (due_results.size() != 0) begin
      errors++;
      $display("%0t: missing results: expected %0d more, got none", $time,
               due_results.size());
    end

    $display("tb: %0d requests checked under %0d timeout settings", result_cnt, cfg_writes);
    $display("tb: %0d frames completed, %0d header errors, %0d rejected bytes, %0d timeouts",
             frames_done, hdr_errors, rejects, timeouts_seen);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
